// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the buddy block allocator.
// Sizes, status codes and the word layout of the level bitmaps.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned Levels    = 11;
  localparam int unsigned MinShift  = 10;  // smallest block is 1 KiB
  localparam int unsigned IdxW      = 10;  // block index
  localparam int unsigned CntW      = 11;  // block counts, 0..1024
  localparam int unsigned LvlW      = 4;
  localparam int unsigned WordW     = 32;  // bitmap word
  localparam int unsigned WordsPerLvl = MaxBlocks / WordW;  // 32
  localparam int unsigned WAddrW    = 9;   // level (4) + word (5)
  localparam int unsigned WSelW     = 5;

  // Request kinds carried in the action field.
  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  // Byte address of the block_count register.
  localparam logic [1:0] RegBlockCount = 2'd0;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StTooLarge = 3'd1,
    StNoSpace  = 3'd2,
    StNoFree   = 3'd3,
    StNotAlloc = 3'd4
  } status_e;

  // Bitmap word address: level in the high bits, word in the low bits.
  function automatic logic [WAddrW-1:0] waddr(input logic [LvlW-1:0] lvl,
                                              input logic [IdxW-1:0] idx);
    return {lvl, idx[IdxW-1:WSelW]};
  endfunction

endpackage

// ===== sv/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator: buddy allocator over a pool of 1 KiB blocks.
// Level bitmaps and the block level table live in synchronous RAMs.
// ----------------------------------------------------------------------------
// Channel   | Direction | Contents
// s_axis    | in        | tdata: action, request_size, free_address
// m_axis    | out       | tdata: status, block_address, block_level
// APB       | in/out    | register 0 at address 0: block_count
//
// The search reads one 32-bit bitmap word at a time, and each split or merge
// step is a read, then a write, of one bitmap word.
// After reset and after each block_count write a clearing pass rewrites both
// RAMs; no item is accepted during it.
// The result waits in an output register; the next item is taken only after
// it has been transferred.
// ----------------------------------------------------------------------------
module buddy_block_allocator import bba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] action, [21:1] request_size, [41:22] free_address, [47:42] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [22:3] block_address, [26:23] block_level, [31:27] zero
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [13:0] {
    SClear   = 14'b00000000000001,
    SIdle    = 14'b00000000000010,
    SScanRd  = 14'b00000000000100,
    SScanChk = 14'b00000000001000,
    SSplitRd = 14'b00000000010000,
    SSplitWr = 14'b00000000100000,
    SLvlWr   = 14'b00000001000000,
    SFreeRd  = 14'b00000010000000,
    SFreeChk = 14'b00000100000000,
    SMergeRd = 14'b00001000000000,
    SMergeWr = 14'b00010000000000,
    SDone    = 14'b00100000000000,
    SResult  = 14'b01000000000000,
    SAllocChk= 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // Bitmap RAM (one word per 32 blocks of a level) and level table RAM.
  logic [WordW-1:0] bmp_mem [2**WAddrW];
  logic [LvlW:0]    lvt_mem [MaxBlocks];  // {valid, level}
  logic [WordW-1:0] bmp_rd_q;
  logic [LvlW:0]    lvt_rd_q;
  logic [WAddrW-1:0] bmp_ra, bmp_wa;
  logic [WordW-1:0] bmp_wd;
  logic              bmp_we;
  logic [IdxW-1:0]  lvt_ra, lvt_wa;
  logic [LvlW:0]    lvt_wd;
  logic              lvt_we;

  always_ff @(posedge clk_i) begin
    if (bmp_we) bmp_mem[bmp_wa] <= bmp_wd;
    bmp_rd_q <= bmp_mem[bmp_ra];
    if (lvt_we) lvt_mem[lvt_wa] <= lvt_wd;
    lvt_rd_q <= lvt_mem[lvt_ra];
  end

  // Control and payload registers.
  logic [CntW-1:0]  bc_q, bc_d;
  logic [LvlW-1:0]  ltot_q, ltot_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [Levels-1:0] nz_q, nz_d;        // level has any free block
  logic [IdxW:0]    clr_q, clr_d;       // clearing pass counter
  logic [LvlW-1:0]  lvl_q, lvl_d;       // requested level
  logic [LvlW-1:0]  cur_q, cur_d;       // level being worked
  logic [IdxW-1:0]  off_q, off_d;       // block index within cur level
  logic [2:0]       st_q, st_d;
  logic [19:0]      oaddr_q, oaddr_d;
  logic [LvlW-1:0]  olvl_q, olvl_d;
  logic              act_q, act_d;
  logic [20:0]      size_q, size_d;
  logic [IdxW-1:0]  fidx_q, fidx_d;
  logic              ovld_q, ovld_d;

  // Configuration write.
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr == RegBlockCount);
  assign prdata = {21'd0, bc_q};

  // Count of levels of a block count: its bit length.
  function automatic logic [LvlW-1:0] bitlen(input logic [CntW-1:0] n);
    logic [LvlW-1:0] r;
    r = '0;
    for (int i = 0; i < CntW; i++) if (n[i]) r = LvlW'(i + 1);
    return r;
  endfunction

  // Number of smallest blocks covered by one block of a level.
  function automatic logic [CntW-1:0] blk_of_lvl_f(input logic [LvlW-1:0] l);
    return CntW'(1) << l;
  endfunction

  // Block count of the current level: block_count >> cur.
  logic [CntW-1:0] nblk_cur;
  assign nblk_cur = bc_q >> cur_q;

  // Word mask of blocks below the level's count.
  logic [WordW-1:0] lim_mask;
  always_comb begin
    for (int b = 0; b < WordW; b++)
      lim_mask[b] = ({off_q[IdxW-1:WSelW], WSelW'(b)} < nblk_cur);
  end

  // Lowest set bit of the masked word.
  logic [WordW-1:0] scan_w;
  logic [WSelW-1:0] scan_pos;
  logic              scan_hit;
  assign scan_w = bmp_rd_q & lim_mask;
  always_comb begin
    scan_pos = '0;
    scan_hit = 1'b0;
    for (int b = WordW - 1; b >= 0; b--)
      if (scan_w[b]) begin
        scan_pos = WSelW'(b);
        scan_hit = 1'b1;
      end
  end

  // Requested level from size.
  logic [LvlW-1:0] req_lvl;
  logic             req_fit;
  always_comb begin
    req_lvl = '0;
    req_fit = 1'b0;
    for (int l = Levels - 1; l >= 0; l--)
      if (LvlW'(l) < ltot_q && {11'd0, size_q} <= (32'd1024 << l)) begin
        req_lvl = LvlW'(l);
        req_fit = 1'b1;
      end
  end

  logic [CntW:0] blk_of_lvl;
  assign blk_of_lvl = (CntW+1)'(1) << lvl_q;

  logic [WSelW-1:0] bsel;
  assign bsel = off_q[WSelW-1:0];
  logic [IdxW-1:0] buddy;
  assign buddy = off_q ^ IdxW'(1);

  logic [IdxW:0] clr_inc;
  assign clr_inc = clr_q + (IdxW+1)'(1);

  always_comb begin
    state_d = state_q;
    bc_d = bc_q; ltot_d = ltot_q; used_d = used_q; nz_d = nz_q; clr_d = clr_q;
    lvl_d = lvl_q; cur_d = cur_q; off_d = off_q;
    st_d = st_q; oaddr_d = oaddr_q; olvl_d = olvl_q; act_d = act_q;
    size_d = size_q; fidx_d = fidx_q; ovld_d = ovld_q;
    bmp_ra = waddr(cur_q, off_q);
    bmp_wa = waddr(cur_q, off_q);
    bmp_wd = bmp_rd_q;
    bmp_we = 1'b0;
    lvt_ra = fidx_q;
    lvt_wa = fidx_q;
    lvt_wd = '0;
    lvt_we = 1'b0;
    s_axis_tready = 1'b0;

    if (ovld_q && m_axis_tready) ovld_d = 1'b0;

    unique case (state_q)
      // Clear both RAMs; the last blocks of odd-count levels are set.
      SClear: begin
        bmp_we = ~clr_q[IdxW] & (clr_q[IdxW-1:WAddrW] == '0);
        bmp_wa = clr_q[WAddrW-1:0];
        for (int b = 0; b < WordW; b++)
          bmp_wd[b] = (clr_q[WAddrW-1:WSelW] < ltot_q) &&
            (bc_q >> clr_q[WAddrW-1:WSelW]) ==
              {1'b0, clr_q[WSelW-1:0], WSelW'(b)} + CntW'(1) &&
            (((bc_q >> clr_q[WAddrW-1:WSelW]) & CntW'(1)) != '0);
        lvt_we = ~clr_q[IdxW];
        lvt_wa = clr_q[IdxW-1:0];
        lvt_wd = '0;
        clr_d = clr_inc;
        if (clr_q[IdxW]) state_d = SIdle;
      end
      SIdle: begin
        s_axis_tready = ~ovld_q;
        if (s_axis_tvalid && !ovld_q) begin
          act_d = s_axis_tdata[0];
          size_d = s_axis_tdata[21:1];
          fidx_d = s_axis_tdata[41:32];
          st_d = StOk; oaddr_d = '0; olvl_d = '0;
          if (s_axis_tdata[0] == ActAlloc) begin
            state_d = SAllocChk;
          end else if ({1'b0, s_axis_tdata[41:32]} >= bc_q) begin
            st_d = StNotAlloc;
            state_d = SDone;
          end else begin
            state_d = SFreeRd;
          end
        end
      end
      SAllocChk: begin
        lvl_d = req_lvl;
        cur_d = req_lvl;
        off_d = '0;
        if (!req_fit) begin
          st_d = StTooLarge;
          state_d = SDone;
        end else if ({1'b0, used_q} + ((CntW+1)'(1) << req_lvl) > {1'b0, bc_q}) begin
          st_d = StNoSpace;
          state_d = SDone;
        end else begin
          state_d = SScanRd;
        end
      end
      // Read one bitmap word; skip empty levels; report no free block past the top.
      SScanRd: begin
        if (cur_q >= ltot_q) begin
          st_d = StNoFree;
          state_d = SDone;
        end else if (!nz_q[cur_q]) begin
          cur_d = cur_q + LvlW'(1);
          off_d = '0;
        end else begin
          bmp_ra = waddr(cur_q, off_q);
          state_d = SScanChk;
        end
      end
      SScanChk: begin
        if (scan_hit) begin
          off_d = {off_q[IdxW-1:WSelW], scan_pos};
          bmp_wd = bmp_rd_q;
          bmp_wd[scan_pos] = 1'b0;
          bmp_we = 1'b1;
          state_d = SSplitRd;
        end else if ({1'b0, off_q[IdxW-1:WSelW], WSelW'(0)} + CntW'(WordW) >= nblk_cur) begin
          nz_d[cur_q] = 1'b0;
          cur_d = cur_q + LvlW'(1);
          off_d = '0;
          state_d = SScanRd;
        end else begin
          off_d = {off_q[IdxW-1:WSelW] + (IdxW-WSelW)'(1), WSelW'(0)};
          state_d = SScanRd;
        end
      end
      // Split down one level at a time until the requested level is reached.
      SSplitRd: begin
        if (cur_q == lvl_q) begin
          state_d = SLvlWr;
        end else begin
          cur_d = cur_q - LvlW'(1);
          off_d = {off_q[IdxW-2:0], 1'b0};
          bmp_ra = waddr(cur_q - LvlW'(1), {off_q[IdxW-2:0], 1'b0});
          state_d = SSplitWr;
        end
      end
      SSplitWr: begin
        bmp_wd = bmp_rd_q;
        bmp_wd[bsel] = 1'b0;
        bmp_wd[bsel + WSelW'(1)] = 1'b1;
        bmp_we = 1'b1;
        nz_d[cur_q] = 1'b1;
        state_d = SSplitRd;
      end
      SLvlWr: begin
        lvt_wa = off_q << lvl_q;
        lvt_wd = {1'b1, lvl_q};
        lvt_we = 1'b1;
        used_d = used_q + blk_of_lvl[CntW-1:0];
        oaddr_d = {off_q << lvl_q, 10'd0};
        olvl_d = lvl_q;
        state_d = SDone;
      end
      SFreeRd: begin
        lvt_ra = fidx_q;
        state_d = SFreeChk;
      end
      SFreeChk: begin
        if (!lvt_rd_q[LvlW] || lvt_rd_q[LvlW-1:0] >= ltot_q) begin
          st_d = StNotAlloc;
          state_d = SDone;
        end else begin
          lvt_wa = fidx_q;
          lvt_wd = '0;
          lvt_we = 1'b1;
          lvl_d = lvt_rd_q[LvlW-1:0];
          cur_d = lvt_rd_q[LvlW-1:0];
          off_d = fidx_q >> lvt_rd_q[LvlW-1:0];
          olvl_d = lvt_rd_q[LvlW-1:0];
          if (used_q >= blk_of_lvl_f(lvt_rd_q[LvlW-1:0]))
            used_d = used_q - blk_of_lvl_f(lvt_rd_q[LvlW-1:0]);
          else
            used_d = '0;
          state_d = SMergeRd;
        end
      end
      SMergeRd: begin
        bmp_ra = waddr(cur_q, off_q);
        state_d = SMergeWr;
      end
      // Merge when the buddy is free and a level is above; else set the block.
      SMergeWr: begin
        bmp_we = 1'b1;
        if (cur_q + LvlW'(1) < ltot_q && {1'b0, buddy} < nblk_cur &&
            bmp_rd_q[buddy[WSelW-1:0]]) begin
          bmp_wd = bmp_rd_q;
          bmp_wd[bsel] = 1'b0;
          bmp_wd[buddy[WSelW-1:0]] = 1'b0;
          cur_d = cur_q + LvlW'(1);
          off_d = off_q >> 1;
          state_d = SMergeRd;
        end else begin
          bmp_wd = bmp_rd_q;
          bmp_wd[bsel] = 1'b1;
          nz_d[cur_q] = 1'b1;
          state_d = SDone;
        end
      end
      SDone: begin
        ovld_d = 1'b1;
        state_d = SResult;
      end
      SResult: begin
        if (!ovld_q) state_d = SIdle;
      end
      default: state_d = SClear;
    endcase

    if (cfg_we) begin
      bc_d = (pwdata[10:0] > CntW'(MaxBlocks)) ? CntW'(MaxBlocks) : pwdata[10:0];
      ltot_d = bitlen(bc_d);
      for (int l = 0; l < Levels; l++)
        nz_d[l] = (LvlW'(l) < ltot_d) && (((bc_d >> l) & CntW'(1)) != '0);
      used_d = '0;
      clr_d = '0;
      state_d = SClear;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      bc_q <= CntW'(MaxBlocks);
      ltot_q <= LvlW'(Levels);
      used_q <= '0;
      nz_q <= Levels'(1) << (Levels - 1);
      clr_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bc_q <= bc_d;
      ltot_q <= ltot_d;
      used_q <= used_d;
      nz_q <= nz_d;
      clr_q <= clr_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d; cur_q <= cur_d; off_q <= off_d;
    st_q <= st_d; oaddr_q <= oaddr_d; olvl_q <= olvl_d; act_q <= act_d;
    size_q <= size_d; fidx_q <= fidx_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = {5'd0, (st_q == StOk) ? olvl_q : 4'd0,
                         (st_q == StOk && act_q == ActAlloc) ? oaddr_q : 20'd0, st_q};

  // Used space never exceeds the pool.
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= bc_q)
    else $error("used space beyond pool");
  // Items are taken only in the idle state.
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == SIdle) else $error("ready outside idle");
  // A result appears in the cycle after the done state.
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDone && !cfg_we) |=> ovld_q) else $error("result lost");

endmodule
